### hdl/gbl_pkg.sv
// Shared types and constants for the gap buffer line editor.
package gbl_pkg;

   // Default number of entries in the character store
   localparam int GBL_STORE_DEPTH = 256;

   // Operation codes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_MOVE   = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   // Last logical address of a clearing sweep
   localparam logic [7:0] SWEEP_LAST = 8'hFF;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] char_in;
      logic [7:0] position;
   } gbl_req_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] char_out;
      logic [7:0] text_length;
      logic [7:0] cursor_out;
   } gbl_rsp_type;

   // One write and one read per cycle, logical (unwrapped) addresses
   typedef struct packed {
      logic       we;
      logic [7:0] waddr;
      logic [7:0] wdata;
      logic [7:0] raddr;
   } gbl_mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MOVE_WD,
      ST_MOVE_WZ,
      ST_READ_WAIT
   } gbl_state_type;

endpackage

### hdl/gbl_store.sv
// Character store: one write port, one registered read port, write-first forwarding.
module gbl_store
   import gbl_pkg::*;
#(
   parameter int STORE_DEPTH = GBL_STORE_DEPTH
) (
   input  logic            clock,
   input  gbl_mem_req_type mem_req,
   output logic [7:0]      rd_data
);

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [7:0]        mem [STORE_DEPTH];
   logic [ADDR_W-1:0] wrap_lut [256];
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;
   logic [7:0]        rd_data_ff;

   // Map a logical address onto the store, wrapping at its depth
   for (genvar i = 0; i < 256; i++) begin : g_wrap
      assign wrap_lut[i] = ADDR_W'(i % STORE_DEPTH);
   end

   assign waddr = wrap_lut[mem_req.waddr];
   assign raddr = wrap_lut[mem_req.raddr];

   // Write the entry
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[waddr] <= mem_req.wdata;
      end
   end

   // Read, forwarding a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (mem_req.we && (waddr == raddr)) begin
         rd_data_ff <= mem_req.wdata;
      end else begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/gbl_ctrl.sv
// Sequencer: cursor, gap and capacity registers, operation decode and result register.
module gbl_ctrl
   import gbl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic [7:0]      csr_write_data,
   input  logic            req_valid,
   output logic            req_ready,
   input  gbl_req_type     req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output gbl_rsp_type     rsp_data,
   output gbl_mem_req_type mem_req,
   input  logic [7:0]      mem_rd_data
);

   gbl_state_type state_ff, state_in;
   logic [7:0]    cap_ff, cap_in;
   logic [7:0]    cursor_ff, cursor_in;
   logic [7:0]    gap_ff, gap_in;
   logic [7:0]    clr_cnt_ff, clr_cnt_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic [7:0]    target_ff, target_in;
   logic          dir_right_ff, dir_right_in;
   logic          rsp_valid_ff, rsp_valid_in;
   gbl_rsp_type   rsp_data_ff, rsp_data_in;

   logic       accept;
   logic       rsp_load;
   logic       rsp_ok;
   logic [7:0] rsp_char;
   logic [7:0] text_len;
   logic [7:0] move_src;
   logic [7:0] move_dst;
   logic [7:0] cursor_step;
   logic       move_ok;
   logic       move_shift;
   logic       read_ok;

   // Decode the current line geometry
   assign text_len    = cap_ff - gap_ff;
   assign req_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready) && !csr_write_en;
   assign accept      = req_valid && req_ready;
   assign move_src    = dir_right_ff ? (cursor_ff + gap_ff) : (cursor_ff - 8'd1);
   assign move_dst    = dir_right_ff ? cursor_ff : (cursor_ff - 8'd1 + gap_ff);
   assign cursor_step = dir_right_ff ? (cursor_ff + 8'd1) : (cursor_ff - 8'd1);
   assign move_ok     = (req_data.position <= text_len);
   assign move_shift  = move_ok && (req_data.position != cursor_ff) && (gap_ff != 8'd0);
   assign read_ok     = (req_data.position < text_len);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_MOVE: begin
                     if (move_shift) begin
                        state_in = ST_MOVE_WD;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  OP_READ: begin
                     if (read_ok) begin
                        state_in = ST_READ_WAIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_cnt_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_MOVE_WD: begin
            state_in = ST_MOVE_WZ;
         end
         ST_MOVE_WZ: begin
            state_in = (cursor_step == target_ff) ? ST_IDLE : ST_MOVE_WD;
         end
         ST_READ_WAIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write_en) begin
         state_in = ST_CLEAR;
      end
   end

   // Datapath and store accesses
   always_comb begin
      cap_in       = cap_ff;
      cursor_in    = cursor_ff;
      gap_in       = gap_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      target_in    = target_ff;
      dir_right_in = dir_right_ff;
      mem_req      = '0;
      rsp_load     = 1'b0;
      rsp_ok       = 1'b0;
      rsp_char     = 8'd0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_INSERT: begin
                     rsp_load = 1'b1;
                     if (gap_ff != 8'd0) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cursor_ff;
                        mem_req.wdata = req_data.char_in;
                        cursor_in     = cursor_ff + 8'd1;
                        gap_in        = gap_ff - 8'd1;
                        rsp_ok        = 1'b1;
                     end
                  end
                  OP_MOVE: begin
                     if (move_shift) begin
                        // start the shift: fetch the first character to carry
                        target_in     = req_data.position;
                        dir_right_in  = (req_data.position > cursor_ff);
                        mem_req.raddr = (req_data.position > cursor_ff) ?
                                        (cursor_ff + gap_ff) : (cursor_ff - 8'd1);
                     end else begin
                        rsp_load = 1'b1;
                        if (move_ok) begin
                           cursor_in = req_data.position;
                           rsp_ok    = 1'b1;
                        end
                     end
                  end
                  OP_DELETE: begin
                     rsp_load = 1'b1;
                     if (cursor_ff < text_len) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cursor_ff + gap_ff;
                        mem_req.wdata = 8'd0;
                        gap_in        = gap_ff + 8'd1;
                        rsp_ok        = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     clr_cnt_in = 8'd0;
                     clr_rsp_in = 1'b1;
                     cursor_in  = 8'd0;
                     gap_in     = cap_ff;
                  end
                  OP_READ: begin
                     if (read_ok) begin
                        mem_req.raddr = (req_data.position < cursor_ff) ?
                                        req_data.position : (req_data.position + gap_ff);
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            // zero one entry per cycle
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_cnt_ff;
            mem_req.wdata = 8'd0;
            clr_cnt_in    = clr_cnt_ff + 8'd1;
            if (clr_cnt_ff == SWEEP_LAST) begin
               rsp_load   = clr_rsp_ff;
               rsp_ok     = 1'b1;
               clr_rsp_in = 1'b0;
            end
         end
         ST_MOVE_WD: begin
            // carry the character across the gap
            mem_req.we    = 1'b1;
            mem_req.waddr = move_dst;
            mem_req.wdata = mem_rd_data;
         end
         ST_MOVE_WZ: begin
            // zero the vacated slot and fetch the next character
            mem_req.we    = 1'b1;
            mem_req.waddr = move_src;
            mem_req.wdata = 8'd0;
            mem_req.raddr = dir_right_ff ? (move_src + 8'd1) : (move_src - 8'd1);
            cursor_in     = cursor_step;
            if (cursor_step == target_ff) begin
               rsp_load = 1'b1;
               rsp_ok   = 1'b1;
            end
         end
         ST_READ_WAIT: begin
            rsp_load = 1'b1;
            rsp_ok   = 1'b1;
            rsp_char = mem_rd_data;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      // capacity write restarts the line
      if (csr_write_en) begin
         cap_in     = csr_write_data;
         gap_in     = csr_write_data;
         cursor_in  = 8'd0;
         clr_cnt_in = 8'd0;
         clr_rsp_in = 1'b0;
         rsp_load   = 1'b0;
      end
   end

   // Build the result word from the updated state
   always_comb begin
      rsp_data_in.ok          = rsp_ok;
      rsp_data_in.char_out    = rsp_char;
      rsp_data_in.text_length = cap_in - gap_in;
      rsp_data_in.cursor_out  = cursor_in;
      rsp_valid_in            = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cap_ff       <= 8'hFF;
         cursor_ff    <= 8'd0;
         gap_ff       <= 8'hFF;
         clr_cnt_ff   <= 8'd0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         cursor_ff    <= cursor_in;
         gap_ff       <= gap_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      dir_right_ff <= dir_right_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/gap_buffer_line_editor.sv
// Top level of the gap buffer line editor: sequencer plus character store.
//
// Usage: one text line kept as a gap buffer. Each request word carries an
// operation (insert, move cursor, delete forward, clear, read character), a
// character and a position; each request yields one response word with ok,
// the character read, text length and cursor, unless a capacity write cuts in.
// Channels: req_* and rsp_* use valid/ready; csr_write_en/csr_write_data
// writes the capacity, which also starts a clearing pass.
// Responses: insert, delete, trivial or refused move, refused read and unknown
// codes answer in the cycle after acceptance; a read answers via ST_READ_WAIT;
// a move that shifts n characters runs ST_MOVE_WD then ST_MOVE_WZ per
// character, one store write for the carried character and one for zeroing
// the vacated slot; clear sweeps the store, one entry per cycle, then answers.
// One request is in progress at a time. Reset and capacity writes run a
// clearing pass over the store, with req_ready low; capacity resets to 255.
// A stalled rsp_ready holds the response register; the next request is
// accepted once the response register is free or being emptied.
module gap_buffer_line_editor
   import gbl_pkg::*;
#(
   parameter int STORE_DEPTH = GBL_STORE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  gbl_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output gbl_rsp_type rsp_data
);

   gbl_mem_req_type mem_req;
   logic [7:0]      mem_rd_data;

   // Operation sequencer
   gbl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data)
   );

   // Character store
   gbl_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTHESIS
   // a request is only taken when the response register can take its word
   a_req_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
      else $error("request accepted while response register is blocked");

   // the cursor never runs past the end of the text
   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cursor_out <= rsp_data.text_length))
      else $error("cursor beyond text length");

   // a capacity write starts a clearing pass
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ready)
      else $error("request channel open right after capacity write");
`endif

endmodule
